// ===== sv/lnpks_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the last-note-priority key stack.
// No dependencies; used by lnpks_cell and the top level.
package lnpks_pkg;

	localparam int CV_W  = 16;
	localparam int VEL_W = 16;
	localparam int CMD_W = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_RSVD     = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RELEASE
	} state_t;

	typedef struct packed {
		logic signed [CV_W-1:0] cv;
		logic [VEL_W-1:0]       vel;
	} key_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic                   push;
		logic                   shift;
		logic signed [CV_W-1:0] rel_cv;
	} cell_ctl_t;

endpackage

// ===== sv/lnpks_cell.sv =====
`timescale 1ns / 1ps
// One slot of the held-key stack: holds a key, pushes down, closes holes upward.
// Depends on lnpks_pkg.
module lnpks_cell (
	input  logic                  clk,
	input  lnpks_pkg::cell_ctl_t  ctl,
	input  lnpks_pkg::key_t       upper,
	input  lnpks_pkg::key_t       lower,
	input  logic                  live,
	input  logic                  hole_in,
	output lnpks_pkg::key_t       cur,
	output logic                  hole_out
);

	lnpks_pkg::key_t key_q;
	logic            match;

	assign match    = live && (key_q.cv == ctl.rel_cv);
	assign hole_out = hole_in || match;
	assign cur      = key_q;

	// push takes the neighbor above; a removal pass takes the neighbor below
	// in every slot at or under the topmost matching key
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			key_q <= upper;
		end else if (ctl.shift && hole_out) begin
			key_q <= lower;
		end
	end

endmodule

// ===== sv/last_note_priority_key_stack_top.sv =====
`timescale 1ns / 1ps
// Top level of the last-note-priority monophonic key stack.
// Depends on lnpks_pkg and lnpks_cell (a chain of STACK_DEPTH cells).
//
//  channel  | direction | word contents (low bit first)
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tuser: cmd[1:0]; tdata: note_cv[15:0], note_velocity[31:16]
//  m_*      | out       | tdata: gate[0], pitch_cv[16:1], level_velocity[32:17], zero pad
//  cfg_*    | in        | data: multi_trigger[0]; always ready
//
// Sequencing: a sample tick or a note on needs no removal pass. A note off
// takes the word, then runs removal passes through the cell chain, each
// removing the topmost held entry with that cv and closing the gap, until a
// pass finds none. The input is not ready during those passes.
// Reset: held count, last cv/velocity and multi_trigger clear; cell contents
// are undefined and never read beyond the held count.
// Stalls: a tick result waits in the output register; the input is held off
// while that register is full and not being taken, and during removal passes.
module last_note_priority_key_stack_top #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lnpks_pkg::IN_DATA_W-1:0]     s_tdata,   // note_cv, note_velocity
	input  logic [lnpks_pkg::CMD_W-1:0]         s_tuser,   // cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lnpks_pkg::OUT_DATA_W-1:0]    m_tdata,   // gate, pitch_cv, level_velocity
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_data   // multi_trigger
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	// registers
	lnpks_pkg::state_t          state_q, state_d;
	logic [CNT_W-1:0]           held_count_q, held_count_d;
	logic signed [lnpks_pkg::CV_W-1:0] rel_cv_q;
	logic signed [lnpks_pkg::CV_W-1:0] last_cv_q;
	logic [lnpks_pkg::VEL_W-1:0]       last_vel_q;
	logic                       multi_trig_q;
	logic                       out_valid_q;
	logic                       out_gate_q;
	logic signed [lnpks_pkg::CV_W-1:0] out_cv_q;
	logic [lnpks_pkg::VEL_W-1:0]       out_vel_q;

	// input word decode
	lnpks_pkg::cmd_t            cmd;
	lnpks_pkg::key_t            in_key;
	logic                       take;
	logic                       take_tick;
	logic                       take_on;
	logic                       take_off;
	logic                       tick_gate;

	// cell chain
	lnpks_pkg::cell_ctl_t       ctl;
	lnpks_pkg::key_t            cell_key [STACK_DEPTH];
	logic [STACK_DEPTH-1:0]     live;
	logic [STACK_DEPTH:0]       hole;
	logic                       any_match;

	assign cmd        = lnpks_pkg::cmd_t'(s_tuser);
	assign in_key.cv  = s_tdata[lnpks_pkg::CV_W-1:0];
	assign in_key.vel = s_tdata[lnpks_pkg::CV_W +: lnpks_pkg::VEL_W];

	assign s_tready  = (state_q == lnpks_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign take      = s_tvalid && s_tready;
	assign take_tick = take && (cmd == lnpks_pkg::CMD_TICK);
	assign take_on   = take && (cmd == lnpks_pkg::CMD_NOTE_ON);
	assign take_off  = take && (cmd == lnpks_pkg::CMD_NOTE_OFF);

	assign cfg_ready = 1'b1;

	assign ctl.push   = take_on;
	assign ctl.shift  = (state_q == lnpks_pkg::ST_RELEASE);
	assign ctl.rel_cv = rel_cv_q;

	assign hole[0]   = 1'b0;
	assign any_match = hole[STACK_DEPTH];

	genvar g;
	generate
		for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
			lnpks_pkg::key_t upper_key;
			lnpks_pkg::key_t lower_key;

			assign live[g] = (held_count_q > CNT_W'(g));

			if (g == 0) begin : g_top
				assign upper_key = in_key;
			end else begin : g_mid
				assign upper_key = cell_key[g-1];
			end

			// bottom slot refills from itself; the count drops past it anyway
			if (g == STACK_DEPTH - 1) begin : g_bot
				assign lower_key = cell_key[g];
			end else begin : g_up
				assign lower_key = cell_key[g+1];
			end

			lnpks_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.upper    (upper_key),
				.lower    (lower_key),
				.live     (live[g]),
				.hole_in  (hole[g]),
				.cur      (cell_key[g]),
				.hole_out (hole[g+1])
			);
		end
	endgenerate

	// gate is low while the stack is empty, and drops for one tick on a pitch change in multi-trigger mode
	assign tick_gate = (held_count_q != '0) &&
		!(multi_trig_q && (last_cv_q != cell_key[0].cv));

	// next state and held count
	always_comb begin
		state_d      = state_q;
		held_count_d = held_count_q;
		case (state_q)
			lnpks_pkg::ST_IDLE: begin
				if (take_on) begin
					if (held_count_q != CNT_W'(STACK_DEPTH)) begin
						held_count_d = held_count_q + CNT_W'(1);
					end
				end else if (take_off) begin
					state_d = lnpks_pkg::ST_RELEASE;
				end
			end
			lnpks_pkg::ST_RELEASE: begin
				if (any_match) begin
					held_count_d = held_count_q - CNT_W'(1);
				end else begin
					state_d = lnpks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lnpks_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lnpks_pkg::ST_IDLE;
			held_count_q <= '0;
			last_cv_q    <= '0;
			last_vel_q   <= '0;
			multi_trig_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			held_count_q <= held_count_d;
			if (cfg_valid && cfg_ready) begin
				multi_trig_q <= cfg_data[0];
			end
			// follow the top key at each tick; hold the last one while the stack is empty
			if (take_tick && (held_count_q != '0)) begin
				last_cv_q  <= cell_key[0].cv;
				last_vel_q <= cell_key[0].vel;
			end
			if (take_tick) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_off) begin
			rel_cv_q <= in_key.cv;
		end
		if (take_tick) begin
			out_gate_q <= tick_gate;
			if (held_count_q != '0) begin
				out_cv_q  <= cell_key[0].cv;
				out_vel_q <= cell_key[0].vel;
			end else begin
				out_cv_q  <= last_cv_q;
				out_vel_q <= last_vel_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_vel_q, out_cv_q, out_gate_q};

	// count never passes the stack depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(STACK_DEPTH))
		else $error("held count above stack depth");

	// no new word is taken while a removal pass is running
	a_release_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lnpks_pkg::ST_RELEASE) |-> !s_tready)
		else $error("input ready during removal pass");

	// a removal pass never grows the stack
	a_release_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lnpks_pkg::ST_RELEASE) |=> (held_count_q <= $past(held_count_q)))
		else $error("held count grew during removal");

	// a tick always leaves a result in the output register
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> m_tvalid)
		else $error("tick without result");

	// a note on leaves at least one key held
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take_on |=> (held_count_q != '0))
		else $error("note on left stack empty");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for last_note_priority_key_stack_top.
// Depends on lnpks_pkg and the key stack RTL; a scoreboard class predicts each tick word.
module tb_top;

	localparam int DEPTH        = 16;
	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE       = 40;	// longer than a note off over a full stack

	typedef struct packed {
		logic                              gate;
		logic signed [lnpks_pkg::CV_W-1:0] cv;
		logic [lnpks_pkg::VEL_W-1:0]       vel;
	} tick_word_t;

	// Held-key stack predictor and tick word scoreboard.
	class key_stack_scoreboard;
		logic signed [lnpks_pkg::CV_W-1:0] held_cv [DEPTH];
		logic [lnpks_pkg::VEL_W-1:0]       held_vel [DEPTH];
		int                                held;
		logic signed [lnpks_pkg::CV_W-1:0] last_cv;
		logic [lnpks_pkg::VEL_W-1:0]       last_vel;
		bit                                retrigger;
		tick_word_t                        expected_ticks [$];
		int                                errors;

		function new();
			held      = 0;
			last_cv   = '0;
			last_vel  = '0;
			retrigger = 1'b0;
			errors    = 0;
		endfunction

		function void set_retrigger(bit on);
			retrigger = on;
		endfunction

		// Apply one accepted input word to the held stack.
		function void note_word(lnpks_pkg::cmd_t cmd, logic signed [lnpks_pkg::CV_W-1:0] cv,
				logic [lnpks_pkg::VEL_W-1:0] vel);
			int n;
			int wr;
			tick_word_t t;
			case (cmd)
				lnpks_pkg::CMD_NOTE_ON: begin
					// full stack: drop the bottom key
					n = (held >= DEPTH) ? DEPTH - 1 : held;
					for (int i = n; i > 0; i--) begin
						held_cv[i]  = held_cv[i-1];
						held_vel[i] = held_vel[i-1];
					end
					held_cv[0]  = cv;
					held_vel[0] = vel;
					held        = n + 1;
				end
				lnpks_pkg::CMD_NOTE_OFF: begin
					wr = 0;
					for (int rd = 0; rd < held; rd++) begin
						if (held_cv[rd] != cv) begin
							held_cv[wr]  = held_cv[rd];
							held_vel[wr] = held_vel[rd];
							wr++;
						end
					end
					held = wr;
				end
				lnpks_pkg::CMD_TICK: begin
					if (held == 0) begin
						t.gate = 1'b0;
					end else begin
						t.gate   = !(retrigger && last_cv != held_cv[0]);
						last_cv  = held_cv[0];
						last_vel = held_vel[0];
					end
					t.cv  = last_cv;
					t.vel = last_vel;
					expected_ticks.insert(expected_ticks.size(), t);
				end
				default: ;
			endcase
		endfunction

		function void check_tick_word(logic [lnpks_pkg::OUT_DATA_W-1:0] word);
			tick_word_t want;
			tick_word_t got;
			got.gate = word[0];
			got.cv   = word[16:1];
			got.vel  = word[32:17];
			if (expected_ticks.size() == 0) begin
				$display("%0t: tick word expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_ticks.pop_front();
			if (got.gate !== want.gate) begin
				$display("%0t: gate expected %0d actual %0d", $time, want.gate, got.gate);
				errors++;
			end
			if (got.cv !== want.cv) begin
				$display("%0t: pitch_cv expected %h actual %h", $time, want.cv, got.cv);
				errors++;
			end
			if (got.vel !== want.vel) begin
				$display("%0t: level_velocity expected %h actual %h", $time, want.vel, got.vel);
				errors++;
			end
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [lnpks_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [lnpks_pkg::CMD_W-1:0]      s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [lnpks_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [0:0]                       cfg_data;

	key_stack_scoreboard sb = new();

	int          sender_idle_pct = 0;
	int          stall_pct       = 0;
	int          hold_cycles     = 0;
	int          cycle_count     = 0;
	logic [15:0] cv_pool [8];

	last_note_priority_key_stack_top #(
		.STACK_DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: check each taken word, then pick ready for the next edge.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_tick_word(m_tdata);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one word after a random gap; return at the edge that takes it.
	task automatic send_word(lnpks_pkg::cmd_t cmd, logic [15:0] cv, logic [15:0] vel);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {vel, cv};
		do @(posedge clk); while (!s_tready);
		sb.note_word(cmd, cv, vel);
	endtask

	// Wait for every tick word, then let any note off pass finish.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_retrigger(bit on);
		cfg_valid <= 1'b1;
		cfg_data  <= on;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_retrigger(on);
	endtask

	// Mostly cvs from a small pool so note offs hit held keys and duplicates.
	function automatic logic [15:0] pick_cv();
		return ($urandom_range(9) < 8) ? cv_pool[$urandom_range(7)] : 16'($urandom);
	endfunction

	task automatic run_phase(int count, int idle, int stall, bit press);
		int sent;
		int r;
		bit pressed;
		sender_idle_pct = idle;
		stall_pct       = stall;
		foreach (cv_pool[i])
			cv_pool[i] = 16'($urandom);
		cv_pool[0] = 16'h8000;
		cv_pool[1] = 16'h7FFF;
		sent    = 0;
		pressed = 1'b0;
		while (sent < count) begin
			if (press && !pressed && sent >= 200) begin
				// hold off the output long enough to back up the input
				hold_cycles = 400;
				pressed     = 1'b1;
			end
			if ($urandom_range(149) == 0)
				cv_pool[$urandom_range(7)] = 16'($urandom);
			r = $urandom_range(99);
			if (r < 2) begin
				// burst of presses: fills the stack and can push out the oldest keys
				repeat ($urandom_range(16, 20)) begin
					send_word(lnpks_pkg::CMD_NOTE_ON, pick_cv(), 16'($urandom));
					sent++;
				end
			end else if (r < 40) begin
				send_word(lnpks_pkg::CMD_TICK, 16'($urandom), 16'($urandom));
				sent++;
			end else if (r < 70) begin
				send_word(lnpks_pkg::CMD_NOTE_ON, pick_cv(), 16'($urandom));
				sent++;
			end else if (r < 93) begin
				send_word(lnpks_pkg::CMD_NOTE_OFF, pick_cv(), 16'($urandom));
				sent++;
			end else begin
				send_word(lnpks_pkg::CMD_RSVD, 16'($urandom), 16'($urandom));
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= lnpks_pkg::CMD_TICK;
		cfg_valid <= 1'b0;
		cfg_data  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: retrigger on, first press after reset, extremes, duplicates.
		write_retrigger(1'b1);
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);	// empty: gate low, cv/vel zero
		send_word(lnpks_pkg::CMD_NOTE_ON, 16'h0000, 16'hFFFF);	// same cv as reset
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_ON, 16'h8000, 16'h0000);
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);	// pitch change: gate low
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_ON, 16'h7FFF, 16'hFFFF);
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_ON, 16'h7FFF, 16'h1234);	// duplicate of a held cv
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_OFF, 16'h5555, 16'hFFFF);	// cv not held
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_RSVD, 16'hFFFF, 16'hFFFF);	// unknown command
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_OFF, 16'h7FFF, 16'h0000);	// removes both entries
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_OFF, 16'h8000, 16'h0000);
		send_word(lnpks_pkg::CMD_NOTE_OFF, 16'h0000, 16'h0000);
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);	// empty again: hold last key
		send_word(lnpks_pkg::CMD_TICK, 16'h0000, 16'h0000);
		drain();

		write_retrigger(1'b0);
		run_phase(410, 0, 0, 1'b1);
		write_retrigger(1'b1);
		run_phase(410, 60, 0, 1'b0);
		write_retrigger(1'b0);
		run_phase(410, 0, 60, 1'b0);
		write_retrigger(1'b1);
		run_phase(410, 16, 16, 1'b0);

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/lnpks_pkg.sv
sv/lnpks_cell.sv
sv/last_note_priority_key_stack_top.sv
verif/tb_top.sv
